// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- design/rme_pkg.sv -----
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types and constants of the modular exponentiation core.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS);
    localparam int IDX_BITS  = 2;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    localparam logic [IDX_BITS-1:0] REG_EXPONENT    = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_MODULUS     = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_BYTE_RESULT = 2'd2;

    typedef struct packed {
        logic [WORD_BITS-1:0] base_value;
        logic                 last_in;
    } rme_in_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] power_value;
        logic                 last_out;
    } rme_out_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED,
        OP_PSTART,
        OP_PSTEP,
        OP_ESHIFT,
        OP_FINISH
    } rme_op_t;

    typedef struct packed {
        rme_op_t op;
        logic    last;
        logic    sel_base;
    } rme_cmd_t;

    typedef struct packed {
        logic exp_bit;
    } rme_sts_t;

endpackage

// ----- design/rme_ctrl.sv -----
// ----------------------------------------------------------------------------
// rme_ctrl
// Sequencer: base reduction, square-and-multiply over exponent bits,
// result hand-off to the output register.
// ----------------------------------------------------------------------------
module rme_ctrl
    import rme_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  rme_sts_t sts,
    output rme_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_SQ_INIT,
        S_SQ,
        S_MUL_INIT,
        S_MUL,
        S_NEXT,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [CNT_BITS-1:0] ecnt_reg, ecnt_next;
    logic                out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ecnt_next      = ecnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '{op: OP_NONE, last: 1'b0, sel_base: 1'b0};
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    cnt_next   = '0;
                    ecnt_next  = '0;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                cmd.op   = OP_RED;
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_SQ_INIT;
                end
            end
            S_SQ_INIT:
            begin
                cmd.op     = OP_PSTART;
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op   = OP_PSTEP;
                cmd.last = (cnt_reg == CNT_LAST);
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = sts.exp_bit ? S_MUL_INIT : S_NEXT;
                end
            end
            S_MUL_INIT:
            begin
                cmd.op       = OP_PSTART;
                cmd.sel_base = 1'b1;
                cnt_next     = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.op   = OP_PSTEP;
                cmd.last = (cnt_reg == CNT_LAST);
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.op    = OP_ESHIFT;
                ecnt_next = ecnt_reg + CNT_BITS'(1);
                state_next = (ecnt_reg == CNT_LAST) ? S_OUT : S_SQ_INIT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ecnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ecnt_reg      <= ecnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- design/rme_dp.sv -----
// ----------------------------------------------------------------------------
// rme_dp
// Datapath: bit-serial base reduction, interleaved add-and-double modular
// multiply, exponent shifter and output register.
// ----------------------------------------------------------------------------
module rme_dp
    import rme_pkg::*;
(
    input  logic                 clk,
    input  rme_cmd_t             cmd,
    output rme_sts_t             sts,
    input  rme_in_t              in_data,
    input  logic [WORD_BITS-1:0] exponent,
    input  logic [WORD_BITS-1:0] modulus,
    input  logic                 byte_result,
    output rme_out_t             out_data
);

    logic [WORD_BITS-1:0] bsh_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] esh_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] pr_reg;
    logic [WORD_BITS-1:0] mb_reg;
    logic                 sel_base_reg;
    logic                 last_reg;
    rme_out_t             out_reg;

    logic [WORD_BITS:0]   mod_ext;
    logic [WORD_BITS:0]   red_sum;
    logic [WORD_BITS-1:0] rem_next;
    logic [WORD_BITS:0]   dbl_sum;
    logic [WORD_BITS-1:0] dbl_mod;
    logic [WORD_BITS-1:0] mul_a;
    logic [WORD_BITS:0]   add_sum;
    logic [WORD_BITS-1:0] add_mod;
    logic [WORD_BITS-1:0] pr_next;
    logic                 mod_small;
    logic [WORD_BITS-1:0] result;

    assign mod_ext = {1'b0, modulus};

    // base reduction: one dividend bit per cycle, remainder stays below 2m
    assign red_sum  = {rem_reg, bsh_reg[WORD_BITS-1]};
    assign rem_next = (red_sum >= mod_ext) ? WORD_BITS'(red_sum - mod_ext)
                                           : red_sum[WORD_BITS-1:0];

    // product step: double, then conditionally add the multiplicand
    assign mul_a   = sel_base_reg ? rem_reg : acc_reg;
    assign dbl_sum = {pr_reg, 1'b0};
    assign dbl_mod = (dbl_sum >= mod_ext) ? WORD_BITS'(dbl_sum - mod_ext)
                                          : dbl_sum[WORD_BITS-1:0];
    assign add_sum = {1'b0, dbl_mod} + {1'b0, mul_a};
    assign add_mod = (add_sum >= mod_ext) ? WORD_BITS'(add_sum - mod_ext)
                                          : add_sum[WORD_BITS-1:0];
    assign pr_next = mb_reg[WORD_BITS-1] ? add_mod : dbl_mod;

    assign mod_small = (modulus[WORD_BITS-1:1] == '0);

    always_comb
    begin
        result = mod_small ? '0 : acc_reg;
        if (byte_result)
        begin
            result = {{(WORD_BITS-8){1'b0}}, result[7:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                bsh_reg  <= in_data.base_value;
                rem_reg  <= '0;
                esh_reg  <= exponent;
                acc_reg  <= WORD_BITS'(1);
                last_reg <= in_data.last_in;
            end
            OP_RED:
            begin
                bsh_reg <= {bsh_reg[WORD_BITS-2:0], 1'b0};
                rem_reg <= rem_next;
            end
            OP_PSTART:
            begin
                pr_reg       <= '0;
                mb_reg       <= acc_reg;
                sel_base_reg <= cmd.sel_base;
            end
            OP_PSTEP:
            begin
                pr_reg <= pr_next;
                mb_reg <= {mb_reg[WORD_BITS-2:0], 1'b0};
                if (cmd.last)
                begin
                    acc_reg <= pr_next;
                end
            end
            OP_ESHIFT:
            begin
                esh_reg <= {esh_reg[WORD_BITS-2:0], 1'b0};
            end
            OP_FINISH:
            begin
                out_reg.power_value <= result;
                out_reg.last_out    <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.exp_bit = esh_reg[WORD_BITS-1];
    assign out_data    = out_reg;

endmodule

// ----- design/rsa_modular_exponentiation_core.sv -----
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation_core
// Computes base_value^exponent mod modulus for each input item (only the low byte when byte_result is set).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries base_value and last_in.
//   Output channel out_valid/out_ready/out_data carries power_value and
//   last_out, one result item per input item, in order.
//   Key registers (exponent, modulus, byte_result) are written through
//   cfg_write/cfg_index/cfg_data; the user must write them only while no
//   item is in flight, as the core does not enforce this. From acceptance
//   to out_valid the core runs the base reduction, then per exponent bit a
//   square, a multiply when the bit is set and an exponent shift, then loads
//   the output register. One item is worked on at a time; the bit-serial
//   modular multiplier works on one multiplier bit per cycle.
//   in_ready is high only while the core is idle.
//   A finished result sits in the output register; a stalled receiver only
//   holds back the hand-off of the next result, and a new item is accepted
//   as soon as the previous one has moved to the output register.
//   Reset clears the sequencer and loads exponent = 1, modulus = all ones,
//   byte_result = 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsa_modular_exponentiation_core
    import rme_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rme_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rme_out_t             out_data,
    input  logic                 cfg_write,
    input  logic [IDX_BITS-1:0]  cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data
);

    logic [WORD_BITS-1:0] exponent_reg;
    logic [WORD_BITS-1:0] modulus_reg;
    logic                 byte_result_reg;

    rme_cmd_t cmd;
    rme_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg    <= WORD_BITS'(1);
            modulus_reg     <= '1;
            byte_result_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_EXPONENT:    exponent_reg    <= cfg_data;
                REG_MODULUS:     modulus_reg     <= cfg_data;
                REG_BYTE_RESULT: byte_result_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    rme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rme_dp u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .sts         (sts),
        .in_data     (in_data),
        .exponent    (exponent_reg),
        .modulus     (modulus_reg),
        .byte_result (byte_result_reg),
        .out_data    (out_data)
    );

    `ASSERT_PROP(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "core ready right after accepting an item")
    `ASSERT_PROP(a_load_on_accept, clk, rst_n, (cmd.op == OP_LOAD) == (in_valid && in_ready), "datapath load out of step with input handshake")
    `ASSERT_PROP(a_finish_sets_valid, clk, rst_n, cmd.op == OP_FINISH |=> out_valid, "result hand-off did not raise out_valid")

endmodule
